// File: rtl/bsbe_pkg.sv
// shared constants and types for the b-spline basis evaluator
package bsbe_pkg;
  localparam int MAX_BASIS  = 32;
  localparam int MAX_ORDER  = 8;
  localparam int KNOT_DEPTH = MAX_BASIS + MAX_ORDER;
  localparam int KW = 17;
  localparam int AW = $clog2(KNOT_DEPTH);
  localparam int NW = $clog2(KNOT_DEPTH);
  localparam logic [KW-1:0] ONE_Q16 = 17'h10000;
  localparam logic [0:0] MODE_WRITE = 1'b0;
  localparam logic [0:0] MODE_EVAL  = 1'b1;
  localparam logic REG_ORDER = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic clr_deg0;  // compute degree-zero value for index
    logic calc;      // compute higher degree value for index
    logic [NW-1:0] idx;
    logic [NW-1:0] ridx;  // basis value read index, one ahead while results leave
    logic [3:0] deg;
    logic [1:0] kstep;  // which knot is being loaded (0..3)
    logic kload;
    logic div_start;
    logic [0:0] div_sel;
    logic wr_nv;
  } bsbe_cmd_t;

  typedef struct packed {
    logic div_done;
  } bsbe_sts_t;
endpackage

// File: rtl/bsbe_ram.sv
// generic ram with one write port and one registered read port
module bsbe_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 40
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/bsbe_div.sv
// restoring divider: floor(num*65536/den) saturated to 1.0, one bit a cycle
module bsbe_div
  import bsbe_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [KW-1:0] num,
  input  logic [KW-1:0] den,
  output logic done,
  output logic [KW-1:0] quo
);
  logic [KW:0] rem;
  logic [33:0] q;
  logic [KW-1:0] d;
  logic [32:0] dvd;
  logic [5:0] cnt;
  logic busy;
  logic [KW+1:0] trial;
  assign trial = {rem, dvd[32]} - {2'b0, d};
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
        rem  <= '0;
        q    <= '0;
        d    <= den;
        dvd  <= {num, 16'b0};
      end else if (busy) begin
        if (!trial[KW+1]) begin
          rem <= trial[KW:0];
          q   <= {q[32:0], 1'b1};
        end else begin
          rem <= {rem[KW-1:0], dvd[32]};
          q   <= {q[32:0], 1'b0};
        end
        dvd <= {dvd[31:0], 1'b0};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd32) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign quo = (d == '0) ? '0 : ((q[32:0] > 33'(ONE_Q16)) ? ONE_Q16 : q[KW-1:0]);
endmodule

// File: rtl/bsbe_datapath.sv
// knot store, basis value memories, weight divider and multiply-add
module bsbe_datapath
  import bsbe_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  bsbe_cmd_t cmd,
  output bsbe_sts_t sts,
  input  logic kwe,
  input  logic [AW-1:0] kwaddr,
  input  logic [KW-1:0] kwdata,
  input  logic [KW-1:0] xin,
  output logic [KW-1:0] out_val
);
  logic [KW-1:0] kr, ki, ki1, kid, kid1, w1, quo, num, den;
  logic [KW-1:0] nva, nvb, nv_wdata;
  logic [AW-1:0] ra;
  logic [1:0] lstep;
  logic n_neg, d_neg;
  logic dn;
  logic [33:0] p1, p2;
  logic [KW:0] s;

  always_comb begin
    unique case (cmd.kstep)
      2'd0: ra = cmd.idx;
      2'd1: ra = AW'(cmd.idx + 1'b1);
      2'd2: ra = AW'(cmd.idx + cmd.deg);
      default: ra = AW'(cmd.idx + cmd.deg + 1'b1);
    endcase
  end

  bsbe_ram #(.WIDTH(KW), .DEPTH(KNOT_DEPTH)) u_knots (
    .clk(clk), .we(kwe), .waddr(kwaddr), .wdata(kwdata), .raddr(ra), .rdata(kr)
  );

  // the knot read data arrives the cycle after kstep names its address, so lstep follows it for kload
  always_ff @(posedge clk) begin
    lstep <= cmd.kstep;
  end

  always_ff @(posedge clk) begin
    if (cmd.kload) begin
      unique case (lstep)
        2'd0: ki <= kr;
        2'd1: ki1 <= kr;
        2'd2: kid <= kr;
        default: kid1 <= kr;
      endcase
    end
  end

  // sign rules: num and den of w1 are x-ki and kid-ki; of w2 kid1-x and kid1-ki1
  always_comb begin
    if (cmd.div_sel == 1'b0) begin
      n_neg = (xin < ki);
      d_neg = (kid < ki);
      num = n_neg ? ki - xin : xin - ki;
      den = d_neg ? ki - kid : kid - ki;
    end else begin
      n_neg = (kid1 < xin);
      d_neg = (kid1 < ki1);
      num = n_neg ? xin - kid1 : kid1 - xin;
      den = d_neg ? ki1 - kid1 : kid1 - ki1;
    end
    // opposite signs give a zero weight
    if (n_neg != d_neg) den = '0;
  end

  bsbe_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(num), .den(den),
    .done(dn), .quo(quo)
  );
  assign sts.div_done = dn;

  always_ff @(posedge clk) begin
    if (dn && cmd.div_sel == 1'b0) begin
      w1 <= quo;
    end
  end

  // two copies of the basis values give two registered reads a cycle
  assign nv_wdata = cmd.clr_deg0 ? ((xin >= ki && xin < ki1) ? ONE_Q16 : '0) :
                    ((s > {1'b0, ONE_Q16}) ? ONE_Q16 : s[KW-1:0]);

  bsbe_ram #(.WIDTH(KW), .DEPTH(KNOT_DEPTH)) u_nv_a (
    .clk(clk), .we(cmd.wr_nv), .waddr(cmd.idx), .wdata(nv_wdata),
    .raddr(cmd.ridx), .rdata(nva)
  );

  bsbe_ram #(.WIDTH(KW), .DEPTH(KNOT_DEPTH)) u_nv_b (
    .clk(clk), .we(cmd.wr_nv), .waddr(cmd.idx), .wdata(nv_wdata),
    .raddr(NW'(cmd.ridx + 1'b1)), .rdata(nvb)
  );

  always_ff @(posedge clk) begin
    p1 <= w1 * nva + 34'd32768;
    p2 <= quo * nvb + 34'd32768;
  end
  assign s = {1'b0, p1[32:16]} + {1'b0, p2[32:16]};

  assign out_val = nva;
endmodule

// File: rtl/bsbe_ctrl.sv
// sequencer for the cox-de boor triangle and result emission
module bsbe_ctrl
  import bsbe_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [3:0] deg_max,
  input  logic [5:0] cnt,
  input  bsbe_sts_t sts,
  output bsbe_cmd_t cmd,
  output logic busy,
  output logic emit,
  output logic [NW-1:0] eidx,
  output logic elast,
  input  logic etake
);
  localparam logic [3:0] S_IDLE = 4'd0, S_K0 = 4'd1, S_K1 = 4'd2, S_K2 = 4'd3,
    S_K3 = 4'd4, S_D0 = 4'd5, S_DIV1 = 4'd6, S_W1 = 4'd7, S_DIV2 = 4'd8,
    S_W2 = 4'd9, S_MUL = 4'd10, S_SUM = 4'd11, S_EMIT = 4'd12, S_K4 = 4'd13,
    S_PRE = 4'd14;
  logic [3:0] state, state_next;
  logic [NW-1:0] idx;
  logic [3:0] deg;
  logic [5:0] span;
  assign span = 6'(cnt + deg_max - deg);
  assign busy = (state != S_IDLE);
  assign emit = (state == S_EMIT);
  assign eidx = idx;
  assign elast = (6'(idx) + 6'd1 == cnt);

  always_comb begin
    cmd = '0;
    cmd.idx = idx;
    cmd.deg = deg;
    // look one index ahead when a result is taken so the next one is ready
    cmd.ridx = (state == S_EMIT && etake) ? NW'(idx + 1'b1) : idx;
    state_next = state;
    unique case (state)
      S_IDLE: if (start) state_next = S_K0;
      S_K0: begin cmd.kstep = 2'd0; state_next = S_K1; end
      S_K1: begin cmd.kstep = 2'd1; cmd.kload = 1'b1; state_next = S_K2; end
      S_K2: begin cmd.kstep = 2'd2; cmd.kload = 1'b1; state_next = S_K3; end
      S_K3: begin cmd.kstep = 2'd3; cmd.kload = 1'b1; state_next = S_K4; end
      S_K4: begin
        cmd.kstep = 2'd3; cmd.kload = 1'b1;
        state_next = (deg == 4'd0) ? S_D0 : S_DIV1;
      end
      S_D0: begin cmd.clr_deg0 = 1'b1; cmd.wr_nv = 1'b1; state_next = S_SUM; end
      S_DIV1: begin cmd.div_start = 1'b1; state_next = S_W1; end
      S_W1: if (sts.div_done) state_next = S_DIV2;
      S_DIV2: begin cmd.div_sel = 1'b1; cmd.div_start = 1'b1; state_next = S_W2; end
      S_W2: begin cmd.div_sel = 1'b1; if (sts.div_done) state_next = S_MUL; end
      S_MUL: begin cmd.div_sel = 1'b1; state_next = S_SUM; cmd.wr_nv = 1'b0; end
      S_SUM: state_next = S_K0;
      S_PRE: state_next = S_EMIT;
      S_EMIT: if (etake && elast) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    if (state == S_SUM) begin
      cmd.wr_nv = (deg != 4'd0);
      if (6'(idx) + 6'd1 >= span) begin
        state_next = (deg == deg_max) ? S_PRE : S_K0;
      end
    end
  end

  // quotient of w2 must stay on the divider output through the multiply
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx <= '0;
      deg <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && start) begin
        idx <= '0; deg <= '0;
      end else if (state == S_SUM) begin
        if (6'(idx) + 6'd1 >= span) begin
          idx <= '0;
          deg <= (deg == deg_max) ? deg : deg + 4'd1;
        end else begin
          idx <= idx + 1'b1;
        end
      end else if (state == S_EMIT && etake) begin
        idx <= elast ? '0 : idx + 1'b1;
      end
    end
  end
endmodule

// File: rtl/bspline_basis_evaluator.sv
// top level of the b-spline basis evaluator
// With order k and basis count n, an evaluate item keeps the block busy
// through the whole triangle: every degree-zero index runs four knot loads
// from the knot memory's single read port, the interval test and the write,
// and every higher-degree index runs the knot loads, two 33-step serial
// divisions for the weights, the multiply and the sum. The first value is
// then fetched and the n result items leave one per cycle as the sink takes
// them. A knot write item gives no result. The next input item
// is accepted the cycle after the last result has gone.
// The knot table holds nothing meaningful until written.
module bspline_basis_evaluator
  import bsbe_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [23:0] s_tdata,   // knot_index[5:0], value[22:6]
  input  logic [0:0] s_tuser,    // mode
  output logic m_tvalid,
  input  logic m_tready,
  output logic [23:0] m_tdata,   // basis_index[4:0], basis_value[21:5], zero pad
  output logic m_tlast,          // last
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  logic [3:0] spline_order;
  logic [5:0] basis_count;
  logic [3:0] deg_max;
  logic [5:0] cnt;
  logic [KW-1:0] x, inval;
  logic acc, busy, emit, elast;
  logic [NW-1:0] eidx;
  logic [KW-1:0] oval;
  bsbe_cmd_t cmd;
  bsbe_sts_t sts;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      spline_order <= 4'd4;
      basis_count <= 6'd8;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      if (paddr[2] == REG_ORDER) spline_order <= pwdata[3:0];
      else basis_count <= pwdata[5:0];
    end
  end
  assign prdata = (paddr[2] == REG_COUNT) ? {26'b0, basis_count} : {28'b0, spline_order};

  // clamp order and count to their supported ranges
  assign deg_max = (spline_order == 4'd0) ? 4'd0 :
                   (spline_order > 4'(MAX_ORDER)) ? 4'(MAX_ORDER - 1) : spline_order - 4'd1;
  assign cnt = (basis_count == 6'd0) ? 6'd1 :
               (basis_count > 6'(MAX_BASIS)) ? 6'(MAX_BASIS) : basis_count;

  // points and knots above one saturate
  assign inval = (s_tdata[22:6] > ONE_Q16) ? ONE_Q16 : s_tdata[22:6];
  assign s_tready = !busy;
  assign acc = s_tvalid && s_tready;
  always_ff @(posedge clk) begin
    if (acc && s_tuser == MODE_EVAL) x <= inval;
  end

  bsbe_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(acc && s_tuser == MODE_EVAL), .deg_max(deg_max),
    .cnt(cnt), .sts(sts), .cmd(cmd), .busy(busy), .emit(emit), .eidx(eidx),
    .elast(elast), .etake(m_tready)
  );

  bsbe_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .kwe(acc && s_tuser == MODE_WRITE && s_tdata[5:0] < 6'(KNOT_DEPTH)),
    .kwaddr(s_tdata[AW-1:0]), .kwdata(inval), .xin(x),
    .out_val(oval)
  );

  assign m_tvalid = emit;
  assign m_tdata = {2'b0, oval, eidx[4:0]};
  assign m_tlast = elast;
endmodule

// File: verif/tb.sv
// self-checking testbench for the b-spline basis evaluator
module tb
  import bsbe_pkg::*;
();

  typedef struct packed {
    logic [0:0]    mode;
    logic [5:0]    kidx;
    logic [KW-1:0] value;
  } knot_item_t;

  typedef struct packed {
    logic [4:0]    idx;
    logic [KW-1:0] value;
    logic          last;
  } basis_res_t;

  logic clk, rst;
  logic s_tvalid, s_tready;
  logic [23:0] s_tdata;
  logic [0:0] s_tuser;
  logic m_tvalid, m_tready;
  logic [23:0] m_tdata;
  logic m_tlast;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  bspline_basis_evaluator dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow copy of the block's knot memory and registers
  logic [KW-1:0] knot_mirror [KNOT_DEPTH];
  logic [3:0] order_cfg;
  logic [5:0] count_cfg;

  knot_item_t pending_items[$];
  knot_item_t cur_item;
  basis_res_t basis_expected[$];

  int fail_cnt = 0, eval_cnt = 0, write_cnt = 0, result_cnt = 0;
  int tx_gap, rx_gap;
  bit tx_idle, rx_idle;
  int hold_cnt;
  logic hold_start;

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("error: %s got %0d expected %0d", what, got, want);
    fail_cnt++;
  endtask

  // q16 ratio, zero on zero span or opposite signs, saturated at one
  function automatic longint knot_weight(input longint num, input longint den);
    longint q;
    if (den == 0 || num == 0) return 0;
    if ((num < 0) != (den < 0)) return 0;
    if (num < 0) num = -num;
    if (den < 0) den = -den;
    q = (num <<< 16) / den;
    return (q > 65536) ? 65536 : q;
  endfunction

  function automatic longint q16_mul(input longint w, input longint n);
    return (w * n + 32768) >>> 16;
  endfunction

  // cox-de boor triangle over the mirrored knots, queues one result per index
  task automatic eval_basis(input logic [KW-1:0] pt);
    longint nv [KNOT_DEPTH];
    longint x, ki, ki1, kid, kid1, s;
    int ord, cnt, deg, span;
    basis_res_t r;
    ord = (order_cfg < 1) ? 1 : (order_cfg > MAX_ORDER) ? MAX_ORDER : order_cfg;
    cnt = (count_cfg < 1) ? 1 : (count_cfg > MAX_BASIS) ? MAX_BASIS : count_cfg;
    deg = ord - 1;
    x = (pt > ONE_Q16) ? 65536 : pt;
    span = cnt + deg;
    for (int i = 0; i < span; i++)
      nv[i] = (x >= knot_mirror[i] && x < knot_mirror[i+1]) ? 65536 : 0;
    for (int d = 1; d <= deg; d++) begin
      span = cnt + deg - d;
      for (int i = 0; i < span; i++) begin
        ki = knot_mirror[i]; ki1 = knot_mirror[i+1];
        kid = knot_mirror[i+d]; kid1 = knot_mirror[i+d+1];
        s = q16_mul(knot_weight(x - ki, kid - ki), nv[i])
          + q16_mul(knot_weight(kid1 - x, kid1 - ki1), nv[i+1]);
        nv[i] = (s > 65536) ? 65536 : s;
      end
    end
    for (int i = 0; i < cnt; i++) begin
      r.idx = i[4:0];
      r.value = nv[i][KW-1:0];
      r.last = (i + 1 == cnt);
      basis_expected.push_back(r);
    end
  endtask

  // sender: one item per handshake, with a random gap before the next one while tx_idle is set
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tuser <= MODE_WRITE;
      tx_gap = 0;
      for (int i = 0; i < KNOT_DEPTH; i++) knot_mirror[i] = '0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (cur_item.mode == MODE_EVAL) begin
          eval_basis(cur_item.value);
          eval_cnt++;
        end else begin
          if (cur_item.kidx < KNOT_DEPTH)
            knot_mirror[cur_item.kidx] = (cur_item.value > ONE_Q16) ? ONE_Q16 : cur_item.value;
          write_cnt++;
        end
      end
      if (!s_tvalid || s_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          s_tdata <= {1'b0, cur_item.value, cur_item.kidx};
          s_tuser <= cur_item.mode;
          s_tvalid <= 1'b1;
          tx_gap = tx_idle ? $urandom_range(0, 19) : 0;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold, counted here so the sender keeps pushing meanwhile
  always @(posedge clk) begin
    if (rst) hold_cnt <= 0;
    else if (hold_start) hold_cnt <= 3000;
    else if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
  end

  // receiver: compare each result with the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_gap = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        result_cnt++;
        if (basis_expected.size() == 0) begin
          report("unexpected result, index", 32'(m_tdata[4:0]), 32'd0);
        end else begin
          basis_res_t e;
          e = basis_expected.pop_front();
          if (m_tdata[4:0] != e.idx)
            report("basis_index", 32'(m_tdata[4:0]), 32'(e.idx));
          if (m_tdata[21:5] != e.value)
            report("basis_value", 32'(m_tdata[21:5]), 32'(e.value));
          if (m_tlast != e.last) report("last", 32'(m_tlast), 32'(e.last));
        end
        rx_gap = rx_idle ? $urandom_range(0, 19) : 0;
      end
      if (hold_cnt != 0) begin
        m_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic apb_write(input logic reg_sel, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00}; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (reg_sel == REG_ORDER) order_cfg = data[3:0];
    else count_cfg = data[5:0];
  endtask

  // block is idle: nothing queued, nothing offered, nothing outstanding
  task automatic wait_idle();
    while (pending_items.size() > 0 || s_tvalid || basis_expected.size() > 0)
      @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic add_item(input logic [0:0] mode, input logic [5:0] kidx,
                          input logic [KW-1:0] value);
    knot_item_t it;
    it.mode = mode; it.kidx = kidx; it.value = value;
    pending_items.push_back(it);
  endtask

  // clamped knot vector: repeated zeros, even interior, repeated ones
  function automatic logic [KW-1:0] clamped_knot(input int i);
    if (i < 8) return '0;
    if (i >= 32) return ONE_Q16;
    return KW'(((i - 7) * 65536) / 25);
  endfunction

  task automatic random_items(input int n);
    int k;
    logic [KW-1:0] v;
    for (int j = 0; j < n; j++) begin
      if ($urandom_range(0, 9) < 6) begin
        // evaluation points, mostly on [0,1], a few drawn over the full 17-bit range
        v = ($urandom_range(0, 9) == 0) ? KW'($urandom) : KW'($urandom_range(0, 65536));
        add_item(MODE_EVAL, 6'($urandom), v);
      end else if ($urandom_range(0, 9) < 7) begin
        // well-formed rewrite: near the clamped knot, keeping order loosely
        k = $urandom_range(0, KNOT_DEPTH - 1);
        v = clamped_knot(k);
        if (k >= 8 && k < 32) v = v + KW'($urandom_range(0, 1000));
        add_item(MODE_WRITE, k[5:0], v);
      end else begin
        add_item(MODE_WRITE, 6'($urandom), KW'($urandom));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    hold_start = 1'b0;
    tx_idle = 1'b0; rx_idle = 1'b0;
    order_cfg = 4'd4; count_cfg = 6'd8;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // fill the whole knot table before any evaluation reads it
    for (int i = 0; i < KNOT_DEPTH; i++) add_item(MODE_WRITE, i[5:0], clamped_knot(i));

    // directed: default registers, field extremes, ignored writes, saturation
    add_item(MODE_EVAL, 6'd0, 17'd0);
    add_item(MODE_EVAL, 6'd63, 17'd32768);
    add_item(MODE_EVAL, 6'd0, ONE_Q16);
    add_item(MODE_EVAL, 6'd0, 17'h1FFFF);
    add_item(MODE_WRITE, 6'd40, 17'd12345);
    add_item(MODE_WRITE, 6'd63, 17'h1FFFF);
    add_item(MODE_WRITE, 6'd39, 17'h1FFFF);
    add_item(MODE_EVAL, 6'd0, 17'd2621);
    wait_idle();

    // order 1, one basis: pure interval test
    apb_write(REG_ORDER, 32'd1);
    apb_write(REG_COUNT, 32'd1);
    add_item(MODE_EVAL, 6'd0, 17'd0);
    add_item(MODE_EVAL, 6'd0, 17'd1);
    wait_idle();

    // largest triangle; the right end of the table gives all zeros
    apb_write(REG_ORDER, 32'd8);
    apb_write(REG_COUNT, 32'd32);
    add_item(MODE_EVAL, 6'd0, 17'd30000);
    add_item(MODE_EVAL, 6'd0, ONE_Q16);
    wait_idle();

    // registers beyond range: clamp to the limits
    apb_write(REG_ORDER, 32'd0);
    apb_write(REG_COUNT, 32'd0);
    add_item(MODE_EVAL, 6'd0, 17'd40000);
    wait_idle();
    apb_write(REG_ORDER, 32'd15);
    apb_write(REG_COUNT, 32'd63);
    add_item(MODE_EVAL, 6'd0, 17'd50000);
    wait_idle();

    // back-pressure: sink holds off while evaluations pile up
    apb_write(REG_ORDER, 32'd1);
    apb_write(REG_COUNT, 32'd4);
    for (int j = 0; j < 8; j++) add_item(MODE_EVAL, 6'd0, KW'($urandom_range(0, 65536)));
    @(posedge clk);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    wait_idle();

    // random phases with random registers and random idling on both sides
    for (int p = 0; p < 6; p++) begin
      tx_idle = (p % 3 != 0);
      rx_idle = (p % 2 != 0);
      apb_write(REG_ORDER, $urandom_range(1, 8));
      apb_write(REG_COUNT, $urandom_range(1, 10));
      random_items(8);
      wait_idle();
    end

    repeat (50) @(posedge clk);
    $display("ran %0d evaluations and %0d knot writes, %0d basis values checked",
             eval_cnt, write_cnt, result_cnt);
    $display("orders 1 to 8, counts 1 to 32, clamped registers, long sink stall");
    if (fail_cnt == 0 && basis_expected.size() == 0) begin
      $display("bspline_basis_evaluator: match");
    end else begin
      $display("bspline_basis_evaluator: mismatch");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("timeout");
    $display("bspline_basis_evaluator: mismatch");
    $finish;
  end
endmodule
